>>> rtl/core/sifb_pkg.sv
// ----------------------------------------------------------------------------
// sifb_pkg: shared types and constants of the stuffed info frame builder
// Transaction payloads, configuration set, queue job format, byte classes
// and output step codes.
// ----------------------------------------------------------------------------
package sifb_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FLAG       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESCAPE     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESC_FLAG   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ESC_ESCAPE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ADDRESS    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CTRL_ZERO  = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CTRL_ONE   = 3'd6;

   // Reset values of the configuration registers
   localparam logic [7:0] RESET_FLAG       = 8'd126;
   localparam logic [7:0] RESET_ESCAPE     = 8'd125;
   localparam logic [7:0] RESET_ESC_FLAG   = 8'd94;
   localparam logic [7:0] RESET_ESC_ESCAPE = 8'd93;
   localparam logic [7:0] RESET_ADDRESS    = 8'd3;
   localparam logic [7:0] RESET_CTRL_ZERO  = 8'd0;
   localparam logic [7:0] RESET_CTRL_ONE   = 8'd64;

   // Byte classes for stuffing
   localparam logic [1:0] CLS_PLAIN  = 2'd0;
   localparam logic [1:0] CLS_FLAG   = 2'd1;
   localparam logic [1:0] CLS_ESCAPE = 2'd2;

   // Output steps of one job
   localparam int         STEP_COUNT     = 9;
   localparam logic [3:0] STEP_FLAG      = 4'd0;
   localparam logic [3:0] STEP_ADDRESS   = 4'd1;
   localparam logic [3:0] STEP_CONTROL   = 4'd2;
   localparam logic [3:0] STEP_HDR_CHECK = 4'd3;
   localparam logic [3:0] STEP_DATA      = 4'd4;
   localparam logic [3:0] STEP_DATA_ESC  = 4'd5;
   localparam logic [3:0] STEP_CHECK     = 4'd6;
   localparam logic [3:0] STEP_CHECK_ESC = 4'd7;
   localparam logic [3:0] STEP_CLOSE     = 4'd8;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] payload;
      logic       end_of_payload;
      logic       sequence_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] line_byte;
      logic       run_last;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0] flag_byte;
      logic [7:0] escape_char;
      logic [7:0] escaped_flag_code;
      logic [7:0] escaped_escape_code;
      logic [7:0] address_byte;
      logic [7:0] control_seq_zero;
      logic [7:0] control_seq_one;
   } cfg_type;

   typedef struct packed {
      logic       has_header;
      logic       sequence_bit;
      logic [7:0] data;
      logic [1:0] data_class;
      logic       last;
      logic [7:0] check;
      logic [1:0] check_class;
   } job_type;

   // Flag match wins over escape match when both registers hold one value
   function automatic logic [1:0] classify(input logic [7:0] value, input cfg_type cfg);
      logic [1:0] cls;
      cls = CLS_PLAIN;
      if (value == cfg.flag_byte) begin
         cls = CLS_FLAG;
      end else if (value == cfg.escape_char) begin
         cls = CLS_ESCAPE;
      end
      return cls;
   endfunction

endpackage

>>> rtl/core/sifb_front.sv
// ----------------------------------------------------------------------------
// sifb_front: transaction intake and classification
// Tracks frame position and the payload checksum, classifies bytes for
// stuffing and pushes one job per accepted transaction into the queue.
// ----------------------------------------------------------------------------
module sifb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sifb_pkg::req_type req_payload,
   input  sifb_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output sifb_pkg::job_type push_job
);

   logic       inside_frame_ff, inside_frame_in;
   logic [7:0] check_ff, check_in;
   logic [7:0] new_check;
   logic       has_header;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   always_comb begin
      has_header = !inside_frame_ff;
      new_check  = (has_header ? 8'd0 : check_ff) ^ req_payload.payload;

      push_job.has_header   = has_header;
      push_job.sequence_bit = req_payload.sequence_bit;
      push_job.data         = req_payload.payload;
      push_job.data_class   = sifb_pkg::classify(req_payload.payload, cfg);
      push_job.last         = req_payload.end_of_payload;
      push_job.check        = new_check;
      push_job.check_class  = sifb_pkg::classify(new_check, cfg);

      inside_frame_in = inside_frame_ff;
      check_in        = check_ff;
      if (push) begin
         // close the frame on the last byte, else keep folding
         inside_frame_in = !req_payload.end_of_payload;
         check_in        = req_payload.end_of_payload ? 8'd0 : new_check;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         check_ff        <= 8'd0;
      end else begin
         inside_frame_ff <= inside_frame_in;
         check_ff        <= check_in;
      end
   end

endmodule

>>> rtl/core/sifb_queue.sv
// ----------------------------------------------------------------------------
// sifb_queue: job queue between front and back
// Two-entry FIFO that lets intake and output stall independently.
// ----------------------------------------------------------------------------
module sifb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sifb_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output sifb_pkg::job_type head_job
);

   localparam int PTR_WIDTH = $clog2(sifb_pkg::QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(sifb_pkg::QUEUE_DEPTH + 1);

   sifb_pkg::job_type entry_ff [sifb_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_WIDTH'(sifb_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(sifb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(sifb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/sifb_back.sv
// ----------------------------------------------------------------------------
// sifb_back: output sequencer
// Walks the enabled steps of the head job, one line byte per cycle while
// not stalled, into an output register; pops the job after its final byte.
// ----------------------------------------------------------------------------
module sifb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sifb_pkg::job_type head_job,
   output logic              pop,
   input  sifb_pkg::cfg_type cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sifb_pkg::rsp_type rsp_payload
);

   logic [3:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   sifb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [sifb_pkg::STEP_COUNT-1:0] mask;
   logic [3:0] cur;
   logic       later;
   logic       fire;
   logic [7:0] ctrl;
   logic [7:0] line_byte;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      mask = '0;
      mask[sifb_pkg::STEP_FLAG]      = head_job.has_header;
      mask[sifb_pkg::STEP_ADDRESS]   = head_job.has_header;
      mask[sifb_pkg::STEP_CONTROL]   = head_job.has_header;
      mask[sifb_pkg::STEP_HDR_CHECK] = head_job.has_header;
      mask[sifb_pkg::STEP_DATA]      = 1'b1;
      mask[sifb_pkg::STEP_DATA_ESC]  = (head_job.data_class != sifb_pkg::CLS_PLAIN);
      mask[sifb_pkg::STEP_CHECK]     = head_job.last;
      mask[sifb_pkg::STEP_CHECK_ESC] = head_job.last &&
                                       (head_job.check_class != sifb_pkg::CLS_PLAIN);
      mask[sifb_pkg::STEP_CLOSE]     = head_job.last;

      // first enabled step at or after the current position
      cur = sifb_pkg::STEP_CLOSE;
      for (int i = sifb_pkg::STEP_COUNT - 1; i >= 0; i--) begin
         if (mask[i] && (4'(i) >= step_ff)) begin
            cur = 4'(i);
         end
      end
      later = 1'b0;
      for (int i = 0; i < sifb_pkg::STEP_COUNT; i++) begin
         if (mask[i] && (4'(i) > cur)) begin
            later = 1'b1;
         end
      end

      ctrl = head_job.sequence_bit ? cfg.control_seq_one : cfg.control_seq_zero;

      unique case (cur)
         sifb_pkg::STEP_FLAG:      line_byte = cfg.flag_byte;
         sifb_pkg::STEP_ADDRESS:   line_byte = cfg.address_byte;
         sifb_pkg::STEP_CONTROL:   line_byte = ctrl;
         sifb_pkg::STEP_HDR_CHECK: line_byte = cfg.address_byte ^ ctrl;
         sifb_pkg::STEP_DATA: begin
            line_byte = (head_job.data_class == sifb_pkg::CLS_PLAIN) ?
                        head_job.data : cfg.escape_char;
         end
         sifb_pkg::STEP_DATA_ESC: begin
            line_byte = (head_job.data_class == sifb_pkg::CLS_FLAG) ?
                        cfg.escaped_flag_code : cfg.escaped_escape_code;
         end
         sifb_pkg::STEP_CHECK: begin
            line_byte = (head_job.check_class == sifb_pkg::CLS_PLAIN) ?
                        head_job.check : cfg.escape_char;
         end
         sifb_pkg::STEP_CHECK_ESC: begin
            line_byte = (head_job.check_class == sifb_pkg::CLS_FLAG) ?
                        cfg.escaped_flag_code : cfg.escaped_escape_code;
         end
         sifb_pkg::STEP_CLOSE:     line_byte = cfg.flag_byte;
         default:                  line_byte = cfg.flag_byte;
      endcase

      fire = head_valid && (!rsp_valid_ff || rsp_ready);
      pop  = fire && !later;

      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.line_byte  = line_byte;
         rsp_data_in.run_last   = !later;
         rsp_data_in.frame_done = (cur == sifb_pkg::STEP_CLOSE);
         step_in                = later ? cur + 4'd1 : sifb_pkg::STEP_FLAG;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= sifb_pkg::STEP_FLAG;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/core/stuffed_info_frame_builder.sv
// ----------------------------------------------------------------------------
// stuffed_info_frame_builder: byte-stuffed information frame builder
// Turns payload byte transactions into line bytes of a stuffed frame with
// header, escaped data, escaped XOR checksum and closing flag.
// ----------------------------------------------------------------------------
// Each request transaction carries one payload byte. The first byte of a
// frame brings out the flag, address, control byte (picked by sequence_bit)
// and address XOR control, unstuffed; every payload byte goes out as itself
// or as an escape pair; the byte marked end_of_payload adds the stuffed XOR
// of all payload bytes and a closing flag flagged by frame_done. run_last
// marks the final response of each request. A request yields 1 to 9
// response transactions, which the output sequencer sends one after
// another; the output sequencer is the rate limit. A two-entry job
// queue lets requests be taken while earlier ones are still being
// sent. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module stuffed_info_frame_builder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  sifb_pkg::req_type                     req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output sifb_pkg::rsp_type                     rsp_payload,
   input  logic                                  csr_we,
   input  logic [sifb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [7:0]                            csr_wdata
);

   sifb_pkg::cfg_type cfg_ff, cfg_in;
   sifb_pkg::job_type push_job, head_job;
   logic              push, pop, queue_full, head_valid;

   // Hold the configuration; decode the write index, drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sifb_pkg::CSR_FLAG:       cfg_in.flag_byte           = csr_wdata;
            sifb_pkg::CSR_ESCAPE:     cfg_in.escape_char         = csr_wdata;
            sifb_pkg::CSR_ESC_FLAG:   cfg_in.escaped_flag_code   = csr_wdata;
            sifb_pkg::CSR_ESC_ESCAPE: cfg_in.escaped_escape_code = csr_wdata;
            sifb_pkg::CSR_ADDRESS:    cfg_in.address_byte        = csr_wdata;
            sifb_pkg::CSR_CTRL_ZERO:  cfg_in.control_seq_zero    = csr_wdata;
            sifb_pkg::CSR_CTRL_ONE:   cfg_in.control_seq_one     = csr_wdata;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flag_byte           <= sifb_pkg::RESET_FLAG;
         cfg_ff.escape_char         <= sifb_pkg::RESET_ESCAPE;
         cfg_ff.escaped_flag_code   <= sifb_pkg::RESET_ESC_FLAG;
         cfg_ff.escaped_escape_code <= sifb_pkg::RESET_ESC_ESCAPE;
         cfg_ff.address_byte        <= sifb_pkg::RESET_ADDRESS;
         cfg_ff.control_seq_zero    <= sifb_pkg::RESET_CTRL_ZERO;
         cfg_ff.control_seq_one     <= sifb_pkg::RESET_CTRL_ONE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept the transaction, track the frame, classify bytes
   sifb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   // Queue: decouple intake from output stalls
   sifb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back: emit one line byte per cycle through the output register when not stalled
   sifb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_job    (head_job),
      .pop         (pop),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> tb/stuffed_info_frame_builder_tb.sv
// ----------------------------------------------------------------------------
// stuffed_info_frame_builder_tb: self-checking bench of the frame builder
// Sends payload byte transactions and predicts every line byte of the stuffed
// frame: header, escaped data, escaped XOR checksum and closing flag. Every
// response is checked field by field against the prediction. Directed tests
// cover the special cases, then randomized phases run under fresh register
// settings, with random stalls on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module stuffed_info_frame_builder_tb;

   typedef logic [sifb_pkg::CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 450;
   localparam int RANDOM_PHASES = 6;
   // Index beyond the register list: a write there must change nothing
   localparam csr_index_type CSR_UNUSED = 3'd7;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   sifb_pkg::req_type   req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   sifb_pkg::rsp_type   rsp_payload;
   logic                csr_we      = 1'b0;
   csr_index_type       csr_index   = '0;
   logic [7:0]          csr_wdata   = '0;

   // Mirror of the block: register set, frame state and payload checksum
   sifb_pkg::cfg_type link_cfg;
   logic              in_frame_model;
   logic [7:0]        payload_xor;

   sifb_pkg::rsp_type line_burst[$];     // line bytes of the transaction being predicted
   sifb_pkg::rsp_type expected_line[$];  // line bytes still owed by the block

   int   error_count = 0;
   int   cycle_count = 0;
   int   stall_left  = 0;
   logic idling_on   = 1'b1;

   stuffed_info_frame_builder dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Prediction
   // --------------------------------------------------------------------------

   function automatic void emit_line(input logic [7:0] value, input logic done);
      sifb_pkg::rsp_type r;
      r.line_byte  = value;
      r.run_last   = 1'b0;
      r.frame_done = done;
      line_burst.push_back(r);
   endfunction

   // Flag match wins over escape match when both registers hold one value
   function automatic void emit_stuffed(input logic [7:0] value);
      if (value == link_cfg.flag_byte) begin
         emit_line(link_cfg.escape_char, 1'b0);
         emit_line(link_cfg.escaped_flag_code, 1'b0);
      end else if (value == link_cfg.escape_char) begin
         emit_line(link_cfg.escape_char, 1'b0);
         emit_line(link_cfg.escaped_escape_code, 1'b0);
      end else begin
         emit_line(value, 1'b0);
      end
   endfunction

   // Work out the line bytes of one payload transaction and queue them
   function automatic void predict_line_bytes(input sifb_pkg::req_type item);
      logic [7:0]        ctrl;
      sifb_pkg::rsp_type r;
      line_burst.delete();
      // Open a frame: header goes out unstuffed; sequence bit counts only here
      if (!in_frame_model) begin
         ctrl = item.sequence_bit ? link_cfg.control_seq_one : link_cfg.control_seq_zero;
         emit_line(link_cfg.flag_byte, 1'b0);
         emit_line(link_cfg.address_byte, 1'b0);
         emit_line(ctrl, 1'b0);
         emit_line(link_cfg.address_byte ^ ctrl, 1'b0);
         in_frame_model = 1'b1;
         payload_xor    = 8'h00;
      end
      emit_stuffed(item.payload);
      payload_xor = payload_xor ^ item.payload;
      // Close the frame: stuffed checksum, then closing flag
      if (item.end_of_payload) begin
         emit_stuffed(payload_xor);
         emit_line(link_cfg.flag_byte, 1'b1);
         in_frame_model = 1'b0;
         payload_xor    = 8'h00;
      end
      foreach (line_burst[i]) begin
         r          = line_burst[i];
         r.run_last = (i == line_burst.size() - 1);
         expected_line.push_back(r);
      end
   endfunction

   // --------------------------------------------------------------------------
   // Checking
   // --------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count = error_count + 1;
   endtask

   // Compare each accepted line byte with the oldest prediction
   always @(posedge clock) begin : check_line_bytes
      sifb_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_line.size() == 0) begin
            report_mismatch($sformatf("unexpected line byte %02h", rsp_payload.line_byte));
         end else begin
            want = expected_line.pop_front();
            if (rsp_payload.line_byte !== want.line_byte) begin
               report_mismatch($sformatf("line_byte %02h, expected %02h",
                                         rsp_payload.line_byte, want.line_byte));
            end
            if (rsp_payload.run_last !== want.run_last) begin
               report_mismatch($sformatf("run_last %b, expected %b",
                                         rsp_payload.run_last, want.run_last));
            end
            if (rsp_payload.frame_done !== want.frame_done) begin
               report_mismatch($sformatf("frame_done %b, expected %b",
                                         rsp_payload.frame_done, want.frame_done));
            end
         end
      end
   end

   // Stall the response channel in short random bursts while idling is on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // --------------------------------------------------------------------------
   // Shared driving tasks
   // --------------------------------------------------------------------------

   // Offer one payload transaction and hold it until the block takes it
   task automatic send_payload_byte(input logic [7:0] data, input logic last,
                                    input logic seq);
      sifb_pkg::req_type item;
      item.payload        = data;
      item.end_of_payload = last;
      item.sequence_bit   = seq;
      // Insert a random gap before the transaction
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      predict_line_bytes(item);
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Drop valid, drain every owed line byte, then let the pipeline settle
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_line.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register; only call with the block idle
   task automatic write_register(input csr_index_type index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         sifb_pkg::CSR_FLAG:       link_cfg.flag_byte           = value;
         sifb_pkg::CSR_ESCAPE:     link_cfg.escape_char         = value;
         sifb_pkg::CSR_ESC_FLAG:   link_cfg.escaped_flag_code   = value;
         sifb_pkg::CSR_ESC_ESCAPE: link_cfg.escaped_escape_code = value;
         sifb_pkg::CSR_ADDRESS:    link_cfg.address_byte        = value;
         sifb_pkg::CSR_CTRL_ZERO:  link_cfg.control_seq_zero    = value;
         sifb_pkg::CSR_CTRL_ONE:   link_cfg.control_seq_one     = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Reset register values: escaping of data and of the checksum
   task automatic test_default_framing();
      // Single-byte frames holding the flag and the escape byte
      send_payload_byte(sifb_pkg::RESET_FLAG, 1'b1, 1'b0);
      send_payload_byte(sifb_pkg::RESET_ESCAPE, 1'b1, 1'b1);
      // Checksum lands on the flag; sequence bit mid-frame is ignored
      send_payload_byte(8'h00, 1'b0, 1'b1);
      send_payload_byte(8'hFF, 1'b0, 1'b0);
      send_payload_byte(8'h81, 1'b1, 1'b1);
      // Checksum lands on the escape byte
      send_payload_byte(8'h01, 1'b0, 1'b0);
      send_payload_byte(8'h7C, 1'b1, 1'b0);
      send_payload_byte(8'hA5, 1'b1, 1'b1);
   endtask

   // Header bytes equal to flag or escape go out raw
   task automatic test_header_not_stuffed();
      wait_until_idle();
      write_register(sifb_pkg::CSR_ADDRESS, sifb_pkg::RESET_FLAG);
      write_register(sifb_pkg::CSR_CTRL_ZERO, sifb_pkg::RESET_ESCAPE);
      write_register(sifb_pkg::CSR_CTRL_ONE, 8'h00);
      send_payload_byte(8'h10, 1'b1, 1'b0);
      send_payload_byte(8'h20, 1'b1, 1'b1);
   endtask

   // Flag and escape share one value: matches escape with the flag code
   task automatic test_flag_equals_escape();
      wait_until_idle();
      write_register(sifb_pkg::CSR_FLAG, 8'h55);
      write_register(sifb_pkg::CSR_ESCAPE, 8'h55);
      send_payload_byte(8'h55, 1'b1, 1'b0);
      send_payload_byte(sifb_pkg::RESET_ESCAPE, 1'b0, 1'b1);
      send_payload_byte(sifb_pkg::RESET_FLAG, 1'b1, 1'b0);
   endtask

   // All registers at zero, then at all ones; unused index has no effect
   task automatic test_register_extremes();
      wait_until_idle();
      for (int i = sifb_pkg::CSR_FLAG; i <= sifb_pkg::CSR_CTRL_ONE; i++) begin
         write_register(csr_index_type'(i), 8'h00);
      end
      send_payload_byte(8'h00, 1'b1, 1'b1);
      wait_until_idle();
      for (int i = sifb_pkg::CSR_FLAG; i <= sifb_pkg::CSR_CTRL_ONE; i++) begin
         write_register(csr_index_type'(i), 8'hFF);
      end
      send_payload_byte(8'hFF, 1'b0, 1'b0);
      send_payload_byte(8'h00, 1'b1, 1'b1);
      wait_until_idle();
      write_register(CSR_UNUSED, 8'hA5);
      send_payload_byte(8'h12, 1'b1, 1'b0);
   endtask

   // Register write inside an open frame applies from the next byte on
   task automatic test_write_mid_frame();
      wait_until_idle();
      write_register(sifb_pkg::CSR_FLAG, sifb_pkg::RESET_FLAG);
      write_register(sifb_pkg::CSR_ESCAPE, sifb_pkg::RESET_ESCAPE);
      send_payload_byte(8'h11, 1'b0, 1'b0);
      wait_until_idle();
      write_register(sifb_pkg::CSR_FLAG, 8'h11);
      write_register(sifb_pkg::CSR_ADDRESS, 8'h99);
      send_payload_byte(8'h22, 1'b0, 1'b1);
      send_payload_byte(8'h11, 1'b1, 1'b0);
   endtask

   // Random frames under random register settings, several phases
   task automatic test_random_frames();
      int         left;
      int         frame_len;
      logic [7:0] value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_until_idle();
         // Run the last phase at full rate on both sides
         idling_on = (phase < RANDOM_PHASES - 1);
         for (int i = sifb_pkg::CSR_FLAG; i <= sifb_pkg::CSR_CTRL_ONE; i++) begin
            case ($urandom_range(0, 5))
               0:       value = 8'h00;
               1:       value = 8'hFF;
               default: value = 8'($urandom_range(0, 255));
            endcase
            write_register(csr_index_type'(i), value);
         end
         // Force the flag-equals-escape case now and then
         if ($urandom_range(0, 3) == 0) begin
            write_register(sifb_pkg::CSR_ESCAPE, link_cfg.flag_byte);
         end
         left = RANDOM_ITEMS / RANDOM_PHASES;
         // Phases may end inside a frame; the next phase picks it up
         while (left > 0) begin
            frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
                                                    : $urandom_range(1, 6);
            for (int k = 0; k < frame_len && left > 0; k++) begin
               // Bias payload toward the stuffed values and the extremes
               case ($urandom_range(0, 7))
                  0:       value = link_cfg.flag_byte;
                  1:       value = link_cfg.escape_char;
                  2:       value = 8'h00;
                  3:       value = 8'hFF;
                  default: value = 8'($urandom_range(0, 255));
               endcase
               send_payload_byte(value, k == frame_len - 1, 1'($urandom_range(0, 1)));
               left = left - 1;
            end
         end
      end
   endtask

   // --------------------------------------------------------------------------
   // Sequence
   // --------------------------------------------------------------------------

   initial begin
      link_cfg.flag_byte           = sifb_pkg::RESET_FLAG;
      link_cfg.escape_char         = sifb_pkg::RESET_ESCAPE;
      link_cfg.escaped_flag_code   = sifb_pkg::RESET_ESC_FLAG;
      link_cfg.escaped_escape_code = sifb_pkg::RESET_ESC_ESCAPE;
      link_cfg.address_byte        = sifb_pkg::RESET_ADDRESS;
      link_cfg.control_seq_zero    = sifb_pkg::RESET_CTRL_ZERO;
      link_cfg.control_seq_one     = sifb_pkg::RESET_CTRL_ONE;
      in_frame_model               = 1'b0;
      payload_xor                  = 8'h00;

      // Hold reset before the tests begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_default_framing();
      test_header_not_stuffed();
      test_flag_equals_escape();
      test_register_extremes();
      test_write_mid_frame();
      test_random_frames();

      // Drain the tail and give the block time for any stray output
      wait_until_idle();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sifb_pkg.sv
rtl/core/sifb_front.sv
rtl/core/sifb_queue.sv
rtl/core/sifb_back.sv
rtl/core/stuffed_info_frame_builder.sv
tb/stuffed_info_frame_builder_tb.sv
